[hdl/nfd_pkg.sv]
package nfd_pkg;

  // payload bytes a frame may carry before data results are suppressed
  localparam int MAX_DATA = 7;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_LEN  = 2'd1;
  localparam logic [1:0] STATUS_BAD_CHK  = 2'd2;

  localparam logic [3:0] POS_MAX = 4'hF;
  localparam logic [6:0] BITS_MAX = 7'h7F;

  typedef struct packed {
    logic       is_end;
    logic [7:0] data_byte;
    logic [2:0] data_index;
    logic       cmd_bit;
    logic [2:0] payload_length;
    logic [1:0] frame_status;
  } res_t;

  function automatic logic [3:0] ones8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int k = 0; k < 8; k++) begin
      n = n + {3'b000, v[k]};
    end
    return n;
  endfunction

endpackage

[hdl/nfd_core.sv]
module nfd_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic [7:0]       frame_byte,
  input  logic             last_byte,
  output logic             res_valid,
  output nfd_pkg::res_t    res
);

  logic [3:0] pos_r, pos_nxt;
  logic       cmd_r, cmd_nxt;
  logic [2:0] len_r, len_nxt;
  logic [3:0] carry_r, carry_nxt;
  logic [6:0] bits_r, bits_nxt;
  logic [3:0] chk_lo_r, chk_lo_nxt;

  logic       cmd_cur;
  logic [2:0] len_cur;
  logic [3:0] len_ext;
  logic       have_data;
  logic [3:0] pop;
  logic [7:0] sum;
  logic [6:0] bits_add;
  logic [5:0] rx_chk;
  logic [1:0] status;

  always_comb begin
    cmd_cur   = (pos_r == 4'd0) ? frame_byte[0]   : cmd_r;
    len_cur   = (pos_r == 4'd0) ? frame_byte[3:1] : len_r;
    len_ext   = {1'b0, len_cur};
    have_data = (pos_r >= 4'd1) && (pos_r <= len_ext) && (len_cur != 3'd0) &&
                (len_ext <= 4'(nfd_pkg::MAX_DATA));

    // check covers whole bytes below L plus the low nibble of byte L
    if (pos_r < len_ext) begin
      pop = nfd_pkg::ones8(frame_byte);
    end else if (pos_r == len_ext) begin
      pop = nfd_pkg::ones8({4'h0, frame_byte[3:0]});
    end else begin
      pop = 4'd0;
    end
    sum      = {1'b0, bits_r} + {4'h0, pop};
    bits_add = sum[7] ? nfd_pkg::BITS_MAX : sum[6:0];

    // at byte L+1 nothing is added, so bits_r is the final count
    rx_chk = {frame_byte[1:0], chk_lo_r};
    if (pos_r != (len_ext + 4'd1)) begin
      status = nfd_pkg::STATUS_BAD_LEN;
    end else if (rx_chk != bits_r[5:0] || bits_r[6]) begin
      status = nfd_pkg::STATUS_BAD_CHK;
    end else begin
      status = nfd_pkg::STATUS_OK;
    end

    res = '0;
    if (last_byte) begin
      res.is_end         = 1'b1;
      res.cmd_bit        = cmd_cur;
      res.payload_length = len_cur;
      res.frame_status   = status;
    end else begin
      res.data_byte  = {frame_byte[3:0], carry_r};
      res.data_index = 3'(pos_r - 4'd1);
    end
    res_valid = advance && (last_byte || have_data);
    if (!last_byte && !have_data) begin
      res.data_byte  = 8'h00;
      res.data_index = 3'd0;
    end

    if (last_byte) begin
      pos_nxt    = 4'd0;
      cmd_nxt    = 1'b0;
      len_nxt    = 3'd0;
      carry_nxt  = 4'h0;
      bits_nxt   = 7'd0;
      chk_lo_nxt = 4'h0;
    end else begin
      pos_nxt    = (pos_r == nfd_pkg::POS_MAX) ? pos_r : pos_r + 4'd1;
      cmd_nxt    = cmd_cur;
      len_nxt    = len_cur;
      carry_nxt  = frame_byte[7:4];
      bits_nxt   = bits_add;
      chk_lo_nxt = (pos_r == len_ext) ? frame_byte[7:4] : chk_lo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 4'd0;
      cmd_r    <= 1'b0;
      len_r    <= 3'd0;
      carry_r  <= 4'h0;
      bits_r   <= 7'd0;
      chk_lo_r <= 4'h0;
    end else if (advance) begin
      pos_r    <= pos_nxt;
      cmd_r    <= cmd_nxt;
      len_r    <= len_nxt;
      carry_r  <= carry_nxt;
      bits_r   <= bits_nxt;
      chk_lo_r <= chk_lo_nxt;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && last_byte) |=> (pos_r == 4'd0 && bits_r == 7'd0))
    else $error("frame state not cleared after last byte");

  a_index_in_length: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res.is_end) |-> ({1'b0, res.data_index} < {1'b0, len_cur}))
    else $error("data index beyond header length");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (res.frame_status != 2'd3))
    else $error("undefined frame status");
`endif

endmodule

[hdl/nfd_oreg.sv]
module nfd_oreg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  nfd_pkg::res_t res,
  input  logic          out_stall,
  output logic          free,
  output logic          out_valid,
  output nfd_pkg::res_t out_res
);

  logic          valid_r, valid_nxt;
  nfd_pkg::res_t res_r;

  assign free      = !valid_r || !out_stall;
  assign valid_nxt = load || (valid_r && out_stall);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

[hdl/nibble_frame_deframer_top.sv]
// Nibble frame deframer.
// Input channel: one frame byte per transfer (in_frame_byte), in_last_byte
// high on the final byte. A transfer happens when in_valid is high and
// in_stall is low.
// Output channel: at most one result per input byte. out_is_end low gives a
// reassembled payload byte with its index; out_is_end high gives the end of
// frame result with command bit, header length and status (0 ok, 1 byte
// count wrong, 2 check mismatch). A transfer happens when out_valid is high
// and out_stall is low.
// Each byte passes the input register, then the result register. Throughput:
// one byte per cycle, sustained while out_stall is low; the only limit is
// the single result register draining.
// A byte with no result still advances the frame state and occupies no
// output slot.
// Reset (rst_n low, synchronous) empties both registers and clears the
// frame state, so the next byte is taken as a header.
// While the receiver stalls, the result is held; one more byte may sit in
// the input register, then in_stall rises until the result drains.
module nibble_frame_deframer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_frame_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_is_end,
  output logic [7:0] out_data_byte,
  output logic [2:0] out_data_index,
  output logic       out_cmd_bit,
  output logic [2:0] out_payload_length,
  output logic [1:0] out_frame_status
);

  // input register
  logic          s1_valid_r, s1_valid_nxt;
  logic [7:0]    s1_byte_r;
  logic          s1_last_r;
  logic          advance;
  logic          oreg_free;
  logic          res_valid;
  nfd_pkg::res_t res;
  nfd_pkg::res_t out_res;

  // the held byte moves on once the result register can take its result
  assign advance      = s1_valid_r && oreg_free;
  assign in_stall     = s1_valid_r && !oreg_free;
  assign s1_valid_nxt = (in_valid && !in_stall) || (s1_valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_frame_byte;
      s1_last_r <= in_last_byte;
    end
  end

  nfd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .frame_byte (s1_byte_r),
    .last_byte  (s1_last_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  nfd_oreg u_oreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .free      (oreg_free),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_is_end         = out_res.is_end;
  assign out_data_byte      = out_res.data_byte;
  assign out_data_index     = out_res.data_index;
  assign out_cmd_bit        = out_res.cmd_bit;
  assign out_payload_length = out_res.payload_length;
  assign out_frame_status   = out_res.frame_status;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import nfd_pkg::*;

  // random part size, in frame bytes
  localparam int unsigned RAND_BYTES  = 1850;
  // final stretch of the run with no idling on either side
  localparam int unsigned CALM_TAIL   = 150;
  // cycles in a row with no transfer on either channel before giving up
  localparam int unsigned QUIET_LIMIT = 2000;
  // settle time once nothing is pending (two-stage pipe, plus margin)
  localparam int unsigned DRAIN       = 16;
  localparam int unsigned MAX_REPORTS = 40;

  // One frame byte as presented on the input channel. Rows marked fixed carry
  // an end-of-frame result written out by hand; all other rows are checked
  // against the deframer state kept below.
  typedef struct {
    logic [7:0] fbyte;
    logic       flast;
    bit         fixed;
    logic       w_cmd;
    logic [2:0] w_len;
    logic [1:0] w_status;
  } row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_frame_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_is_end;
  logic [7:0] out_data_byte;
  logic [2:0] out_data_index;
  logic       out_cmd_bit;
  logic [2:0] out_payload_length;
  logic [1:0] out_frame_status;

  nibble_frame_deframer_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_frame_byte     (in_frame_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_is_end        (out_is_end),
    .out_data_byte     (out_data_byte),
    .out_data_index    (out_data_index),
    .out_cmd_bit       (out_cmd_bit),
    .out_payload_length(out_payload_length),
    .out_frame_status  (out_frame_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Directed frames, straight after reset:
  //   one-byte frames at both header extremes (byte count wrong),
  //   a good zero-length frame and one with a bad check,
  //   a full seven-byte frame of all ones (largest possible check),
  //   a frame cut short before its last data byte completes,
  //   a frame with one byte too many.
  row_t dir_rows [22] = '{
    '{8'hFF, 1'b1, 1'b1, 1'b1, 3'd7, STATUS_BAD_LEN},
    '{8'h00, 1'b1, 1'b1, 1'b0, 3'd0, STATUS_BAD_LEN},
    '{8'h00, 1'b0, 1'b0, 1'b0, 3'd0, STATUS_OK},
    '{8'h00, 1'b1, 1'b1, 1'b0, 3'd0, STATUS_OK},
    '{8'h01, 1'b0, 1'b0, 1'b0, 3'd0, STATUS_OK},
    '{8'h00, 1'b1, 1'b1, 1'b1, 3'd0, STATUS_BAD_CHK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 3'd0, STATUS_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 3'd0, STATUS_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 3'd0, STATUS_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 3'd0, STATUS_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 3'd0, STATUS_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 3'd0, STATUS_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 3'd0, STATUS_OK},
    '{8'hCF, 1'b0, 1'b0, 1'b0, 3'd0, STATUS_OK},
    '{8'hFF, 1'b1, 1'b1, 1'b1, 3'd7, STATUS_OK},
    '{8'h06, 1'b0, 1'b0, 1'b0, 3'd0, STATUS_OK},
    '{8'h12, 1'b0, 1'b0, 1'b0, 3'd0, STATUS_OK},
    '{8'h34, 1'b1, 1'b1, 1'b0, 3'd3, STATUS_BAD_LEN},
    '{8'h02, 1'b0, 1'b0, 1'b0, 3'd0, STATUS_OK},
    '{8'h11, 1'b0, 1'b0, 1'b0, 3'd0, STATUS_OK},
    '{8'h00, 1'b0, 1'b0, 1'b0, 3'd0, STATUS_OK},
    '{8'h00, 1'b1, 1'b1, 1'b0, 3'd1, STATUS_BAD_LEN}
  };

  row_t        frame_rows [$];   // every byte to send, in order
  res_t        pending_res [$];  // results still owed by the block
  int unsigned sent_cnt = 0;     // bytes transferred so far
  int unsigned err_cnt = 0;
  int unsigned quiet_cnt = 0;
  int unsigned in_gap = 0;
  int unsigned out_hold = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  logic        no_idle = 1'b0;

  // Deframer state, mirrors the block between frame bytes
  logic [3:0] pos_q = '0;
  logic       hdr_cmd = 1'b0;
  logic [2:0] hdr_len = '0;
  logic [3:0] carry_nib = '0;
  logic [6:0] ones_cnt = '0;
  logic [3:0] chk_lo = '0;

  // Advance the deframer by one byte; returns 1 when the byte yields a result.
  function automatic bit deframe_byte(input logic [7:0] b, input logic fin,
                                      output res_t r);
    int unsigned p;
    int unsigned len;
    int unsigned sum;
    logic [5:0]  rx_chk;
    bit          has_data;
    logic [7:0]  dbyte;
    p = pos_q;
    r = '0;
    if (p == 0) begin
      hdr_cmd = b[0];
      hdr_len = b[3:1];
    end
    len = hdr_len;
    // payload byte i completes when frame byte i+1 arrives
    has_data = p >= 1 && p <= len && len >= 1 && len <= MAX_DATA;
    dbyte = {b[3:0], carry_nib};
    // check covers bytes 0..L-1 and the low nibble of byte L
    if (p <= len) begin
      sum = ones_cnt + ((p < len) ? $countones(b) : $countones(b[3:0]));
      ones_cnt = (sum > BITS_MAX) ? BITS_MAX : 7'(sum);
      if (p == len) chk_lo = b[7:4];
    end
    carry_nib = b[7:4];
    if (fin) begin
      rx_chk = {b[1:0], chk_lo};
      r.is_end = 1'b1;
      r.cmd_bit = hdr_cmd;
      r.payload_length = hdr_len;
      if (p != len + 1) begin
        r.frame_status = STATUS_BAD_LEN;
      end else if (rx_chk == ones_cnt) begin
        r.frame_status = STATUS_OK;
      end else begin
        r.frame_status = STATUS_BAD_CHK;
      end
      pos_q = '0;
      hdr_cmd = 1'b0;
      hdr_len = '0;
      carry_nib = '0;
      ones_cnt = '0;
      chk_lo = '0;
      return 1'b1;
    end
    if (pos_q != POS_MAX) pos_q = pos_q + 4'd1;
    if (has_data) begin
      r.data_byte = dbyte;
      r.data_index = 3'(p - 1);
    end
    return has_data;
  endfunction

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("%0t: %s expected %0d actual %0d", $time, fname, want, got);
    end
  endtask

  // Input side: on each transfer update the deframer and queue what it owes,
  // then either hold, idle for a burst, or present the next byte.
  always @(posedge clk) begin : feed_bytes
    int unsigned ptr;
    res_t        r;
    row_t        s;
    ptr = sent_cnt;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        s = frame_rows[ptr];
        if (deframe_byte(s.fbyte, s.flast, r)) begin
          if (s.fixed) begin
            r = '{is_end: 1'b1, data_byte: 8'h00, data_index: 3'd0,
                  cmd_bit: s.w_cmd, payload_length: s.w_len,
                  frame_status: s.w_status};
          end
          pending_res.push_back(r);
        end
        ptr++;
      end
      if (!(in_valid && in_stall)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (ptr < frame_rows.size()) begin
          if (!in_calm && ptr + CALM_TAIL < frame_rows.size() &&
              $urandom_range(0, 5) == 0) begin
            in_gap = $urandom_range(1, 16) - 1;
            in_valid <= 1'b0;
          end else begin
            in_valid <= 1'b1;
            in_frame_byte <= frame_rows[ptr].fbyte;
            in_last_byte <= frame_rows[ptr].flast;
          end
        end else begin
          in_valid <= 1'b0;
        end
        if ($urandom_range(0, 47) == 0) in_calm = !in_calm;
      end
      no_idle <= (ptr + CALM_TAIL >= frame_rows.size());
    end
    sent_cnt = ptr;
  end

  // Output side: check each transfer against the oldest owed result, and
  // stall in bursts.
  always @(posedge clk) begin : drain_results
    res_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_res.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: unexpected result expected none actual end=%0d data=%0d",
                     $time, out_is_end, out_data_byte);
        end else begin
          want = pending_res.pop_front();
          check_field("is_end", want.is_end, out_is_end);
          check_field("data_byte", want.data_byte, out_data_byte);
          check_field("data_index", want.data_index, out_data_index);
          check_field("cmd_bit", want.cmd_bit, out_cmd_bit);
          check_field("payload_length", want.payload_length, out_payload_length);
          check_field("frame_status", want.frame_status, out_frame_status);
        end
      end
      if (out_hold > 0) begin
        out_hold--;
        out_stall <= 1'b1;
      end else if (!out_calm && !no_idle && $urandom_range(0, 5) == 0) begin
        out_hold = $urandom_range(1, 16) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
      if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
    end
  end

  // Watchdog: a run with no transfer on either side for too long is dead.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cnt <= 0;
      end else if (quiet_cnt >= QUIET_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end else begin
        quiet_cnt <= quiet_cnt + 1;
      end
    end
  end

  initial begin : run
    logic [7:0]  fb [$];
    row_t        row;
    int unsigned rand_bytes;
    int unsigned kind;
    int unsigned cut;
    int unsigned k;
    int unsigned bsel;
    logic        cmd;
    logic [2:0]  flen;
    logic [5:0]  chk;
    logic [7:0]  d;
    rand_bytes = 0;
    foreach (dir_rows[i]) frame_rows.push_back(dir_rows[i]);
    // Random frames: mostly well formed with random content, the rest with a
    // corrupted bit, cut short, padded past their end, or plain noise.
    while (rand_bytes < RAND_BYTES) begin
      kind = $urandom_range(0, 99);
      cmd = 1'($urandom);
      flen = 3'($urandom);
      fb.delete();
      fb.push_back({4'h0, flen, cmd});
      for (int i = 1; i <= flen + 1; i++) fb.push_back(8'h00);
      // payload byte i: low nibble rides in byte i, high nibble in byte i+1
      for (int i = 0; i < flen; i++) begin
        d = 8'($urandom);
        fb[i][7:4] = d[3:0];
        fb[i + 1][3:0] = d[7:4];
      end
      chk = '0;
      for (int i = 0; i < flen; i++) chk = chk + 6'($countones(fb[i]));
      chk = chk + 6'($countones(fb[flen][3:0]));
      fb[flen][7:4] = chk[3:0];
      fb[flen + 1] = {6'($urandom), chk[5:4]};
      if (kind >= 70 && kind < 80) begin
        k = $urandom_range(0, fb.size() - 1);
        bsel = $urandom_range(0, 7);
        fb[k][bsel] = ~fb[k][bsel];
      end else if (kind >= 80 && kind < 88) begin
        cut = $urandom_range(1, flen + 1);
        while (fb.size() > cut) void'(fb.pop_back());
      end else if (kind >= 88 && kind < 95) begin
        // long pads push the byte position into saturation
        repeat ($urandom_range(1, 20)) fb.push_back(8'($urandom));
      end else if (kind >= 95) begin
        fb.delete();
        repeat ($urandom_range(1, 12)) fb.push_back(8'($urandom));
      end
      for (int i = 0; i < fb.size(); i++) begin
        row = '{fb[i], i == fb.size() - 1, 1'b0, 1'b0, 3'd0, STATUS_OK};
        frame_rows.push_back(row);
      end
      rand_bytes += fb.size();
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk);
    while (sent_cnt < frame_rows.size() || pending_res.size() != 0);
    repeat (DRAIN) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
